/* src/lls_pkg.sv */
// Package for the LIFO list with search and delete.
// Sizes, operation codes, the cell control struct and the value fold function.
// No dependencies.
`default_nettype none

package lls_pkg;

    // list geometry
    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int LEN_W      = $clog2(DEPTH + 1);
    localparam int COUNT_W    = 5;

    // beat widths
    localparam int IN_VALUE_W = 32;
    localparam int FUNC_W     = 2;
    localparam int OUT_DATA_W = 8;

    // operation codes carried in s_tuser
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;

    typedef logic [VALUE_BITS-1:0] val_t;

    // control broadcast to every cell
    typedef struct packed {
        logic push;    // shift down, cell 0 takes the key
        logic remove;  // cells at and below the first match shift up
    } cell_ctrl_t;

    // sign-extend the 32-bit input, keep VALUE_BITS bits
    function automatic val_t fold_value(input logic [IN_VALUE_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[VALUE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/lls_cell.sv */
// One cell of the list: a value, a valid bit and a match comparator.
// Depends on lls_pkg.
`default_nettype none

module lls_cell (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire lls_pkg::cell_ctrl_t ctrl,
    input  wire lls_pkg::val_t    key,
    input  wire lls_pkg::val_t    prev_val,
    input  wire                   prev_vld,
    input  wire lls_pkg::val_t    next_val,
    input  wire                   next_vld,
    input  wire                   hit_in,
    output logic                  hit_out,
    output lls_pkg::val_t         val,
    output logic                  vld
);
    import lls_pkg::*;

    val_t val_reg;
    logic vld_reg;
    logic match;

    // a hit here or anywhere above
    assign match   = vld_reg && (val_reg == key);
    assign hit_out = hit_in | match;

    // value: no reset needed
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            val_reg <= prev_val;
        end else if (ctrl.remove && hit_out) begin
            val_reg <= next_val;
        end
    end

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ctrl.push) begin
            vld_reg <= prev_vld;
        end else if (ctrl.remove && hit_out) begin
            vld_reg <= next_vld;
        end
    end

    assign val = val_reg;
    assign vld = vld_reg;

endmodule

`default_nettype wire

/* src/lifo_list_with_search_delete_core.sv */
// Top level of the LIFO list with search and delete: cell chain plus result register.
// Depends on lls_pkg and lls_cell.
//
//  channel | dir | payload
//  s_      | in  | tdata[31:0] value; tuser[1:0] func
//  m_      | out | tdata[0] found, [1] full_drop, [6:2] count, [7] zero
//
// One beat per cycle unless a full result register stalls on m_: all cells compare
// in parallel, the first-match chain ripples down the row, and every cell loads its
// new value at the same edge. A beat is taken whenever the result register is empty
// or being drained, so a stalled m_ side holds at most one result. Reset empties the
// list and the result register.
`default_nettype none

module lifo_list_with_search_delete_core (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [lls_pkg::IN_VALUE_W-1:0]    s_tdata,  // value
    input  wire [lls_pkg::FUNC_W-1:0]        s_tuser,  // func
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [lls_pkg::OUT_DATA_W-1:0]   m_tdata   // found, full_drop, count, pad
);
    import lls_pkg::*;

    logic [LEN_W-1:0]      length_reg, length_next;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic       accept;
    logic       full;
    logic       is_push, is_remove, is_find;
    logic       push_ok, found;
    val_t       key;
    cell_ctrl_t ctrl;

    val_t cell_val [DEPTH];
    logic cell_vld [DEPTH];
    logic hit      [DEPTH+1];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // decode
    assign key       = fold_value(s_tdata);
    assign full      = (length_reg == LEN_W'(DEPTH));
    assign is_push   = (s_tuser == FUNC_PUSH);
    assign is_remove = (s_tuser == FUNC_REMOVE);
    assign is_find   = (s_tuser == FUNC_FIND);
    assign push_ok   = accept && is_push && !full;
    assign found     = hit[DEPTH] && (is_remove || is_find);

    assign ctrl.push   = push_ok;
    assign ctrl.remove = accept && is_remove;

    // row of cells, first-match chain runs top to bottom
    assign hit[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        val_t nv;
        logic nvld;
        val_t pv;
        logic pvld;

        if (i == 0) begin : g_top
            assign pv   = key;
            assign pvld = 1'b1;
        end else begin : g_mid
            assign pv   = cell_val[i-1];
            assign pvld = cell_vld[i-1];
        end

        if (i == DEPTH - 1) begin : g_bot
            assign nv   = '0;
            assign nvld = 1'b0;
        end else begin : g_low
            assign nv   = cell_val[i+1];
            assign nvld = cell_vld[i+1];
        end

        lls_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .key      (key),
            .prev_val (pv),
            .prev_vld (pvld),
            .next_val (nv),
            .next_vld (nvld),
            .hit_in   (hit[i]),
            .hit_out  (hit[i+1]),
            .val      (cell_val[i]),
            .vld      (cell_vld[i])
        );
    end

    // length update
    always_comb begin
        length_next = length_reg;
        if (push_ok) begin
            length_next = length_reg + LEN_W'(1);
        end else if (accept && is_remove && hit[DEPTH]) begin
            length_next = length_reg - LEN_W'(1);
        end
    end

    // result beat
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[0] = found;
        m_tdata_next[1] = is_push && full;
        m_tdata_next[2 +: COUNT_W] = COUNT_W'(length_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            length_reg <= length_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
